>>> design/fhbc_pkg.sv
// Package for the single/half/bfloat16 format converter.
// Function codes and the request/response payload types; no dependencies.
`default_nettype none
package fhbc_pkg;
   typedef enum logic [1:0] {
      FUNC_F32_TO_F16  = 2'd0,
      FUNC_F16_TO_F32  = 2'd1,
      FUNC_F32_TO_BF16 = 2'd2,
      FUNC_BF16_TO_F32 = 2'd3
   } func_type;

   typedef struct packed {
      logic [1:0]  func;
      logic [31:0] in_bits;
   } req_type;

   typedef struct packed {
      logic [31:0] out_bits;
   } rsp_type;

   localparam logic [15:0] H_QNAN = 16'h7E00;
   localparam logic [15:0] H_INF  = 16'h7C00;
   localparam logic [15:0] BF_QUIET = 16'h0040;
   localparam logic [31:0] F32_EXP_MASK = 32'h7F80_0000;
endpackage
`default_nettype wire

>>> design/fhbc_if.sv
// Valid/ready channel interface carrying one payload word.
// Payload type is a parameter; used with fhbc_pkg types.
`default_nettype none
interface fhbc_if #(parameter type payload_type = logic [31:0]);
   logic        valid;
   logic        ready;
   payload_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

>>> design/float_half_bfloat_converter_unit.sv
// Top level of the single/half/bfloat16 format converter.
// Depends on fhbc_pkg, fhbc_if and fhbc_convert.
//
//   channel   direction  payload
//   req       in         func[1:0], in_bits[31:0]
//   rsp       out        out_bits[31:0]
//
// One transaction per cycle while rsp is not stalled; each passes through the input and result registers.
// Both registers advance together whenever the result register is empty or being taken.
// A stall on rsp holds both stages and drops req.ready.
// Synchronous reset clears the valid bits only.
`default_nettype none
module float_half_bfloat_converter_unit (
   input wire clock,
   input wire reset,
   fhbc_if.sink   req,
   fhbc_if.source rsp
);
   import fhbc_pkg::*;

   logic    s1_valid_ff, s1_valid_in;
   req_type s1_data_ff;
   logic    s2_valid_ff, s2_valid_in;
   rsp_type s2_data_ff, conv;
   logic    advance;

   fhbc_convert u_convert (.req(s1_data_ff), .rsp(conv));

   assign advance     = !s2_valid_ff || rsp.ready;
   assign req.ready   = advance;
   assign s1_valid_in = advance ? req.valid : s1_valid_ff;
   assign s2_valid_in = advance ? s1_valid_ff : s2_valid_ff;
   assign rsp.valid   = s2_valid_ff;
   assign rsp.payload = s2_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
      end
      if (advance) begin
         s1_data_ff <= req.payload;
         s2_data_ff <= conv;
      end
   end

`ifndef SYNTH
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && !rsp.ready |=> rsp.valid && $stable(rsp.payload))
      else $error("result changed under stall");
   a_fill: assert property (@(posedge clock) disable iff (reset)
      req.valid && req.ready |=> s1_valid_ff)
      else $error("accepted transaction lost");
   a_move: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && advance |=> rsp.valid)
      else $error("stage one did not reach result");
`endif
endmodule
`default_nettype wire

>>> design/fhbc_convert.sv
// Combinational conversion between single, half and bfloat16 words.
// Depends on fhbc_pkg.
`default_nettype none
module fhbc_convert (
   input  wire fhbc_pkg::req_type req,
   output fhbc_pkg::rsp_type      rsp
);
   import fhbc_pkg::*;

   logic [31:0] w;
   logic [7:0]  e;
   logic [22:0] m;
   logic [15:0] sgn16;
   logic [15:0] half_r;
   logic [14:0] q_norm;
   logic [12:0] rem_norm;
   logic [23:0] sig;
   logic [4:0]  sh;
   logic [23:0] q_sub;
   logic [23:0] rem_sub;
   logic [23:0] hw_sub;
   logic [15:0] h;
   logic [4:0]  he;
   logic [9:0]  hm;
   logic [3:0]  lz;
   logic [9:0]  hm_n;
   logic [31:0] single_r;
   logic [31:0] bf_sum;
   logic [15:0] bf_r;

   always_comb begin
      w = req.in_bits;
      e = w[30:23];
      m = w[22:0];
      sgn16 = {w[31], 15'd0};
      q_norm = {5'(e - 8'd112), m[22:13]};
      rem_norm = m[12:0];
      sig = {1'b1, m};
      sh = 5'(8'd126 - e);
      q_sub = sig >> sh;
      rem_sub = sig & ((24'd1 << sh) - 24'd1);
      hw_sub = 24'd1 << (sh - 5'd1);
      if (e == 8'hFF) begin
         half_r = sgn16 | ((m != '0) ? H_QNAN : H_INF);
      end else if (e >= 8'd143) begin
         half_r = sgn16 | H_INF;
      end else if (e >= 8'd113) begin
         if (rem_norm > 13'h1000 || (rem_norm == 13'h1000 && q_norm[0])) begin
            half_r = sgn16 | {1'b0, 15'(q_norm + 15'd1)};
         end else begin
            half_r = sgn16 | {1'b0, q_norm};
         end
      end else if (e == 8'd0 || e < 8'd102) begin
         half_r = sgn16;
      end else if (rem_sub > hw_sub || (rem_sub == hw_sub && q_sub[0])) begin
         half_r = sgn16 | 16'(q_sub + 24'd1);
      end else begin
         half_r = sgn16 | q_sub[15:0];
      end

      h = w[15:0];
      he = h[14:10];
      hm = h[9:0];
      lz = 4'd0;
      for (int i = 9; i >= 0; i--) begin
         if (hm[i] && lz == 4'd0) lz = 4'(10 - i);
      end
      hm_n = 10'(hm << lz);
      if (he == 5'h1F) begin
         single_r = {h[15], 8'hFF, (hm != '0), hm[8:0], 13'd0};
      end else if (he != 5'd0) begin
         single_r = {h[15], 8'(he + 8'd112), hm, 13'd0};
      end else if (hm == '0) begin
         single_r = {h[15], 31'd0};
      end else begin
         single_r = {h[15], 8'(8'd113 - 8'(lz)), hm_n, 13'd0};
      end

      bf_sum = w + 32'h7FFF + {31'd0, w[16]};
      if (w[30:0] > F32_EXP_MASK[30:0]) begin
         bf_r = w[31:16] | BF_QUIET;
      end else if (e == 8'd0) begin
         bf_r = sgn16;
      end else begin
         bf_r = bf_sum[31:16];
      end

      unique case (func_type'(req.func))
         FUNC_F32_TO_F16:  rsp.out_bits = {16'd0, half_r};
         FUNC_F16_TO_F32:  rsp.out_bits = single_r;
         FUNC_F32_TO_BF16: rsp.out_bits = {16'd0, bf_r};
         FUNC_BF16_TO_F32: rsp.out_bits = {w[15:0], 16'd0};
         default:          rsp.out_bits = '0;
      endcase
   end
endmodule
`default_nettype wire

>>> tb/fhbc_checker.sv
// Checker for the format converter: watches req and rsp, predicts each result.
// Depends on fhbc_pkg and fhbc_if.
module fhbc_checker (
   input  wire clock,
   input  wire reset,
   fhbc_if.sink req,
   fhbc_if.sink rsp,
   output int   fail_count,
   output int   pending
);
   timeunit 1ns;
   timeprecision 1ps;
   import fhbc_pkg::*;

   logic [31:0] expected_words[$];

   function automatic logic [31:0] single_to_half(logic [31:0] w);
      logic [31:0] sgn, e, m, q, rem, halfway, sh, sig;
      sgn = {16'd0, w[31], 15'd0};
      e = {24'd0, w[30:23]};
      m = {9'd0, w[22:0]};
      if (e == 32'hFF) return sgn | (m != 0 ? {16'd0, H_QNAN} : {16'd0, H_INF});
      if (e >= 143) return sgn | {16'd0, H_INF};
      if (e >= 113) begin
         q = ((e - 112) << 10) | (m >> 13);
         rem = m & 32'h1FFF;
         if (rem > 32'h1000 || (rem == 32'h1000 && q[0])) q = q + 1;
         return sgn | q;
      end
      if (e == 0) return sgn;
      sh = 126 - e;
      if (sh >= 25) return sgn;
      sig = m | 32'h80_0000;
      q = sig >> sh;
      rem = sig & ((32'd1 << sh) - 1);
      halfway = 32'd1 << (sh - 1);
      if (rem > halfway || (rem == halfway && q[0])) q = q + 1;
      return sgn | q;
   endfunction

   function automatic logic [31:0] half_to_single(logic [15:0] h);
      logic [31:0] sgn, e, m, ex;
      sgn = {h[15], 31'd0};
      e = {27'd0, h[14:10]};
      m = {22'd0, h[9:0]};
      if (e == 31) begin
         if (m == 0) return sgn | F32_EXP_MASK;
         return sgn | F32_EXP_MASK | 32'h0040_0000 | (m << 13);
      end
      if (e != 0) return sgn | ((e + 112) << 23) | (m << 13);
      if (m == 0) return sgn;
      ex = 113;
      while (m[10] == 1'b0) begin
         m = m << 1;
         ex = ex - 1;
      end
      return sgn | (ex << 23) | ((m & 32'h3FF) << 13);
   endfunction

   function automatic logic [31:0] single_to_bfloat(logic [31:0] w);
      logic [31:0] t;
      if ({1'b0, w[30:0]} > F32_EXP_MASK) return {16'd0, w[31:16] | BF_QUIET};
      if ((w & F32_EXP_MASK) == 0) return {16'd0, w[31], 15'd0};
      t = w + 32'h7FFF + {31'd0, w[16]};
      return {16'd0, t[31:16]};
   endfunction

   function automatic logic [31:0] convert_word(req_type r);
      case (func_type'(r.func))
         FUNC_F32_TO_F16: return single_to_half(r.in_bits);
         FUNC_F16_TO_F32: return half_to_single(r.in_bits[15:0]);
         FUNC_F32_TO_BF16: return single_to_bfloat(r.in_bits);
         default: return {r.in_bits[15:0], 16'd0};
      endcase
   endfunction

   assign pending = expected_words.size();

   always @(posedge clock) begin
      logic [31:0] want;
      if (reset) begin
         fail_count <= 0;
      end else begin
         if (req.valid && req.ready) expected_words.push_back(convert_word(req.payload));
         if (rsp.valid && rsp.ready) begin
            if (expected_words.size() == 0) begin
               $display("%t unexpected out_bits %h", $time, rsp.payload);
               fail_count <= fail_count + 1;
            end else begin
               want = expected_words.pop_front();
               if (want !== rsp.payload) begin
                  $display("%t out_bits expected %h actual %h", $time, want, rsp.payload);
                  fail_count <= fail_count + 1;
               end
            end
         end
      end
   end
endmodule

>>> tb/float_half_bfloat_converter_unit_tb.sv
// Top of the format converter testbench: clock, reset, stimulus and verdict.
// Depends on fhbc_pkg, fhbc_if, fhbc_checker and the converter unit.
module float_half_bfloat_converter_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import fhbc_pkg::*;

   localparam int WATCHDOG_LIMIT = 2000;

   logic clock = 0;
   logic reset = 1;
   int fail_count, pending;
   int send_idle_pct = 0, stall_pct = 0;
   int quiet_cycles = 0;

   fhbc_if #(.payload_type(req_type)) req_ch ();
   fhbc_if #(.payload_type(rsp_type)) rsp_ch ();

   float_half_bfloat_converter_unit dut (
      .clock(clock), .reset(reset), .req(req_ch.sink), .rsp(rsp_ch.source)
   );
   fhbc_checker checker_inst (
      .clock(clock), .reset(reset), .req(req_ch.sink), .rsp(rsp_ch.sink),
      .fail_count(fail_count), .pending(pending)
   );

   always #4 clock = ~clock;

   initial begin
      req_ch.valid = 0;
      req_ch.payload = '0;
      rsp_ch.ready = 0;
   end

   always @(posedge clock) begin
      if (!reset) rsp_ch.ready <= ($urandom_range(99) >= stall_pct);
   end

   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   task automatic send_word(func_type f, logic [31:0] w);
      while ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 0;
         @(posedge clock);
      end
      req_ch.valid <= 1;
      req_ch.payload <= '{func: f, in_bits: w};
      do @(posedge clock); while (!req_ch.ready);
   endtask

   function automatic logic [31:0] random_word();
      logic [31:0] w;
      w = $urandom;
      case ($urandom_range(7))
         0: w[30:23] = 8'hFF;
         1: w[30:23] = 8'h00;
         2: w[30:23] = 8'($urandom_range(143, 100));
         3: w[14:10] = $urandom_range(1) ? 5'h1F : 5'h00;
         4: w[12:0] = 13'h1000;
         5: w[15:0] = 16'(16'h7FFF + $urandom_range(1));
         default: ;
      endcase
      return w;
   endfunction

   initial begin
      logic [31:0] directed[$];
      func_type f;
      directed = '{32'h0000_0000, 32'h8000_0000, 32'h7F80_0000, 32'hFF80_0000,
                   32'h7FC0_0001, 32'hFF80_0001, 32'h477F_F000, 32'h477F_E000,
                   32'h3380_0000, 32'h3300_0001, 32'h0000_0001, 32'h387F_F000,
                   32'h7F7F_FFFF, 32'hFFFF_83FF, 32'h0000_7C01, 32'h0000_0001,
                   32'h3F80_8000, 32'h3F81_8000, 32'hFFFF_FFFF, 32'h0001_8000};
      repeat (12) @(posedge clock);
      reset <= 0;
      foreach (directed[i]) begin
         f = func_type'(i % 4);
         send_word(f, directed[i]);
      end
      for (int i = 0; i < 1200; i++) begin
         case (i / 300)
            0: begin send_idle_pct = 0; stall_pct = 0; end
            1: begin send_idle_pct = 68; stall_pct = 0; end
            2: begin send_idle_pct = 0; stall_pct = 68; end
            default: begin send_idle_pct = 22; stall_pct = 22; end
         endcase
         f = func_type'($urandom_range(3));
         send_word(f, random_word());
      end
      req_ch.valid <= 0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      if (fail_count == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end
endmodule

>>> filelist.f
design/fhbc_pkg.sv
design/fhbc_if.sv
design/fhbc_convert.sv
design/float_half_bfloat_converter_unit.sv
tb/fhbc_checker.sv
tb/float_half_bfloat_converter_unit_tb.sv
